>>> src/vsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_pkg: shared widths and constants of the vibration deviation detector
// Field widths, accumulator widths sized for the largest window, and the
// operand widths of the serial multiplier and square-root units.
// ----------------------------------------------------------------------------
package vsd_pkg;

   // Stream fields
   localparam int SAMPLE_W = 16;
   localparam int THR_W    = 16;
   localparam int Q4_W     = 19;

   // Accumulators, sized for a window of up to 64 samples
   localparam int SUM_W    = 22;
   localparam int SUMSQ_W  = 38;

   // Window spread D = W*sumsq - sum^2, and the root of 256*D
   localparam int DEV_W    = 44;
   localparam int ROOT_W   = 26;
   localparam int RAD_W    = 2 * ROOT_W;

   // Serial multiplier operands and product
   localparam int MUL_A_W  = SUMSQ_W;
   localparam int MUL_B_W  = SUM_W;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   // Threshold after reset
   localparam logic [THR_W-1:0] THR_RESET = 16'd500;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [DEV_W-1:0]    dev_type;
   typedef logic [ROOT_W-1:0]   root_type;

endpackage

>>> src/vsd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_mul: unsigned shift-and-add multiplier, one multiplier bit per cycle
// A start pulse captures both operands; the product is valid while done is
// high.
// ----------------------------------------------------------------------------
module vsd_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vsd_pkg::MUL_A_W-1:0] op_a,
   input  logic [vsd_pkg::MUL_B_W-1:0] op_b,
   output logic                        done,
   output logic [vsd_pkg::MUL_P_W-1:0] prod
);
   import vsd_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

   logic [MUL_A_W-1:0] a_ff;
   logic [MUL_P_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff, done_ff;
   logic [MUL_A_W:0]   upper;

   // Add the multiplicand under the current multiplier bit, then shift right
   always_comb begin
      upper   = {1'b0, prod_ff[MUL_P_W-1:MUL_B_W]}
              + ({1'b0, a_ff} & {(MUL_A_W + 1){prod_ff[0]}});
      prod_in = {upper, prod_ff[MUL_B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_LAST);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // Operand capture and product shift register
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= op_a;
         prod_ff <= {{MUL_A_W{1'b0}}, op_b};
      end else if (run_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

>>> src/vsd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_sqrt: restoring integer square root of 256*D, one root bit per cycle
// Two radicand bits enter the partial remainder each cycle; the floor of the
// root is valid while done is high.
// ----------------------------------------------------------------------------
module vsd_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  vsd_pkg::dev_type   dev,
   output logic               done,
   output vsd_pkg::root_type  root
);
   import vsd_pkg::*;

   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff, done_ff;
   logic [REM_W+1:0]  rem_t, trial;

   // Try subtracting 4*root+1 from the widened remainder
   always_comb begin
      rem_t = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial = {2'b00, root_ff, 2'b01};
      if (rem_t >= trial) begin
         rem_in  = REM_W'(rem_t - trial);
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = REM_W'(rem_t);
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_LAST);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // Radicand, remainder and root shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {dev, {(RAD_W - DEV_W){1'b0}}};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> src/vibration_stddev_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibration_stddev_detector_unit: windowed standard deviation and threshold
// Takes one unsigned sample per beat; after each non-overlapping window of
// WINDOW samples it returns the deviation (4 fraction bits) and a flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 16-bit sample per beat. Ready is high only while idle.
//   rsp_*  : one beat per completed window, none for the other samples.
//   csr_*  : threshold register, always ready; write it while idle.
// Sequence:
//   Each sample is squared by the 22-step serial multiplier before the next
//   sample is taken. The sample that closes a window adds four more serial
//   multiplies (W*sumsq, sum^2, W*thr, its square), then the square root
//   and the division by WINDOW, before the result beat.
// Reset:
//   Clears the accumulators and the sample count, empties the output register
//   and sets the threshold to 500.
// Stall:
//   A result waits in the output register; the block keeps taking samples of
//   the next window and holds only if a second result is ready before the
//   first has been taken.
// ----------------------------------------------------------------------------
module vibration_stddev_detector_unit #(
   parameter int WINDOW = 10
) (
   input  logic        clock,
   input  logic        reset,
   // Threshold write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,    // [15:0] vibration_threshold
   // Sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [18:0] intensity_q4, [19] vibration_on, [23:20] zero
);
   import vsd_pkg::*;

   localparam int CNT_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);
   localparam int DREM_W = $clog2(WINDOW + 1);
   localparam logic [DREM_W:0] DIVISOR = (DREM_W + 1)'(WINDOW);
   localparam int DCNT_W = $clog2(ROOT_W);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(ROOT_W - 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQR  = 4'd1;
   localparam logic [3:0] S_WSQ  = 4'd2;
   localparam logic [3:0] S_SUM2 = 4'd3;
   localparam logic [3:0] S_WTH  = 4'd4;
   localparam logic [3:0] S_LIM  = 4'd5;
   localparam logic [3:0] S_ROOT = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_PUSH = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [THR_W-1:0]   thr_ff;
   sample_type         samp_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SUM_W-1:0]   sum_ff, sum_add;
   logic [SUMSQ_W-1:0] sumsq_ff, sumsq_add;
   dev_type            dev_ff;
   logic               flag_ff;
   root_type           dq_ff;
   logic [DREM_W-1:0]  drem_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic [DREM_W:0]    dtrial;
   logic               dbit;
   logic               rsp_valid_ff;
   logic [Q4_W-1:0]    rsp_q4_ff;
   logic               rsp_flag_ff;

   logic               mul_start, mul_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_prod;
   logic               sqrt_start, sqrt_done;
   root_type           sqrt_root;
   logic               push;

   vsd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   vsd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .dev   (dev_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign sum_add   = sum_ff + SUM_W'(samp_ff);
   assign sumsq_add = sumsq_ff + mul_prod[SUMSQ_W-1:0];
   assign push      = (state_ff == S_PUSH) && (!rsp_valid_ff || rsp_tready);

   // One restoring division step by WINDOW
   assign dtrial = {drem_ff, dq_ff[ROOT_W-1]};
   assign dbit   = (dtrial >= DIVISOR);

   // Sequencer: next state and unit launches
   always_comb begin
      state_in   = state_ff;
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(req_tdata);
               mul_b     = MUL_B_W'(req_tdata);
               state_in  = S_SQR;
            end
         end
         S_SQR: begin
            if (mul_done) begin
               if (cnt_ff == CNT_LAST) begin
                  mul_start = 1'b1;
                  mul_a     = sumsq_add;
                  mul_b     = MUL_B_W'(WINDOW);
                  state_in  = S_WSQ;
               end else begin
                  state_in  = S_IDLE;
               end
            end
         end
         S_WSQ: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(sum_ff);
               mul_b     = sum_ff;
               state_in  = S_SUM2;
            end
         end
         S_SUM2: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(thr_ff);
               mul_b     = MUL_B_W'(WINDOW);
               state_in  = S_WTH;
            end
         end
         S_WTH: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(mul_prod[MUL_B_W-1:0]);
               mul_b     = mul_prod[MUL_B_W-1:0];
               state_in  = S_LIM;
            end
         end
         S_LIM: begin
            if (mul_done) begin
               sqrt_start = 1'b1;
               state_in   = S_ROOT;
            end
         end
         S_ROOT: begin
            if (sqrt_done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (dcnt_ff == DCNT_LAST) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (push) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THR_RESET;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
         // Fold the squared sample into the window, or close the window
         if (state_ff == S_SQR && mul_done) begin
            sum_ff   <= sum_add;
            sumsq_ff <= sumsq_add;
            cnt_ff   <= (cnt_ff == CNT_LAST) ? '0 : cnt_ff + 1'b1;
         end
         if (state_ff == S_SUM2 && mul_done) begin
            sum_ff   <= '0;
            sumsq_ff <= '0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         samp_ff <= req_tdata;
      end
      if (state_ff == S_WSQ && mul_done) begin
         dev_ff <= mul_prod[DEV_W-1:0];
      end
      if (state_ff == S_SUM2 && mul_done) begin
         dev_ff <= dev_ff - mul_prod[DEV_W-1:0];
      end
      if (state_ff == S_LIM && mul_done) begin
         flag_ff <= (dev_ff > mul_prod[DEV_W-1:0]);
      end
      // Load the root, then shift out one quotient bit per cycle
      if (state_ff == S_ROOT && sqrt_done) begin
         dq_ff   <= sqrt_root;
         drem_ff <= '0;
         dcnt_ff <= '0;
      end else if (state_ff == S_DIV) begin
         dq_ff   <= {dq_ff[ROOT_W-2:0], dbit};
         drem_ff <= dbit ? DREM_W'(dtrial - DIVISOR) : DREM_W'(dtrial);
         dcnt_ff <= dcnt_ff + 1'b1;
      end
      if (push) begin
         rsp_q4_ff   <= dq_ff[Q4_W-1:0];
         rsp_flag_ff <= flag_ff;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_flag_ff, rsp_q4_ff};

   // An accepted sample always starts its squaring pass
   a_accept_squares: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SQR))
      else $error("accepted sample did not start squaring");

   // Multiplier results only arrive in a multiply state
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_SQR || state_ff == S_WSQ || state_ff == S_SUM2
                    || state_ff == S_WTH || state_ff == S_LIM))
      else $error("multiplier finished outside a multiply state");

   // A finished window waits while the output register is full and stalled
   a_push_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && rsp_tvalid && !rsp_tready) |=> (state_ff == S_PUSH))
      else $error("result overwrote a stalled output beat");

endmodule

>>> tb/vibration_stddev_detector_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibration_stddev_detector_unit_test: self-checking bench for the detector
// Streams samples into the block with random gaps and back-pressure, predicts
// each window's deviation and vibration flag in step with accepted beats, and
// compares every result beat with the oldest pending window. Covers extreme
// samples, the threshold boundary, a window split by a threshold write, and
// random windows under several thresholds.
// ----------------------------------------------------------------------------
module vibration_stddev_detector_unit_test;
   import vsd_pkg::*;

   localparam int WINDOW_LEN   = 10;
   localparam int DRAIN_CYCLES = 250;

   typedef struct packed {
      logic [Q4_W-1:0] intensity_q4;
      logic            vibration_on;
   } deviation_result_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [THR_W-1:0]  csr_data   = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata  = '0;    // [15:0] sample
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;          // [18:0] intensity_q4, [19] vibration_on

   // Predicted block state
   logic [THR_W-1:0]  alarm_threshold = THR_RESET;
   int                window_fill     = 0;
   longint unsigned   window_sum      = 0;
   longint unsigned   window_sumsq    = 0;
   deviation_result_type pending_windows[$];

   int                fault_count = 0;
   bit                steady_flow = 1'b0;
   int                ready_left  = 0;

   vibration_stddev_detector_unit #(
      .WINDOW(WINDOW_LEN)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, sometimes a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (steady_flow) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 40);
      end
      return $urandom_range(41, 300);
   endfunction

   // Floor of the square root, one result bit per step
   function automatic longint unsigned floor_root(input longint unsigned radicand);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned probe;
      rest  = radicand;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rest) begin
         probe = probe >> 2;
      end
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Accumulate one accepted sample; close the window when it is full
   task automatic tally_sample(input sample_type value);
      longint unsigned wide;
      longint unsigned spread;
      longint unsigned limit;
      longint unsigned scaled_root;
      deviation_result_type outcome;
      wide         = 64'(value);
      window_fill  = window_fill + 1;
      window_sum   = window_sum + wide;
      window_sumsq = window_sumsq + wide * wide;
      if (window_fill == WINDOW_LEN) begin
         spread      = 64'(WINDOW_LEN) * window_sumsq - window_sum * window_sum;
         scaled_root = floor_root(spread << 8) / 64'(WINDOW_LEN);
         limit       = 64'(WINDOW_LEN) * 64'(alarm_threshold);
         limit       = limit * limit;
         outcome.intensity_q4 = scaled_root[Q4_W-1:0];
         outcome.vibration_on = (spread > limit);
         pending_windows.push_back(outcome);
         window_fill  = 0;
         window_sum   = 0;
         window_sumsq = 0;
      end
   endtask

   // Present one sample, hold it until taken, then maybe drop valid for a gap
   task automatic send_sample(input sample_type value);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      tally_sample(value);
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stop sending, let every pending window arrive, then let the block settle
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      alarm_threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One window of a random shape: flat, two-level, full range or banded
   task automatic send_random_window(input int max_span_log);
      int          shape;
      int          span_log;
      logic [16:0] base;
      logic [16:0] level_hi;
      logic [16:0] value;
      shape    = $urandom_range(0, 9);
      span_log = $urandom_range(0, max_span_log);
      base     = 17'($urandom_range(0, 65535));
      level_hi = 17'($urandom_range(0, 65535));
      for (int k = 0; k < WINDOW_LEN; k++) begin
         case (shape)
            0: begin
               value = base;
            end
            1: begin
               value = (k % 2 != 0) ? level_hi : base;
            end
            2: begin
               value = 17'($urandom_range(0, 65535));
            end
            default: begin
               value = 17'(base + $urandom_range(0, (1 << span_log) - 1));
            end
         endcase
         // clip banded samples at full scale
         if (value > 17'd65535) begin
            value = 17'd65535;
         end
         send_sample(value[15:0]);
      end
   endtask

   // Largest possible spread under the reset threshold
   task automatic test_extremes();
      for (int k = 0; k < WINDOW_LEN; k++) begin
         send_sample((k % 2 != 0) ? 16'hFFFF : 16'h0000);
      end
   endtask

   // Deviation exactly at the threshold, then one unit above it, the second
   // window split by a threshold write
   task automatic test_threshold_boundary();
      write_threshold(16'd100);
      for (int k = 0; k < WINDOW_LEN; k++) begin
         send_sample((k < WINDOW_LEN / 2) ? 16'd0 : 16'd200);
      end
      for (int k = 0; k < WINDOW_LEN / 2; k++) begin
         send_sample(16'd0);
      end
      write_threshold(16'd99);
      for (int k = 0; k < WINDOW_LEN / 2; k++) begin
         send_sample(16'd200);
      end
   endtask

   task automatic test_zero_threshold();
      write_threshold(16'd0);
      repeat (8) send_random_window(16);
   endtask

   task automatic test_full_threshold();
      write_threshold(16'hFFFF);
      repeat (8) send_random_window(16);
   endtask

   // Thresholds on the scale of the window spread, so the flag goes both ways
   task automatic test_matched_scale();
      for (int p = 0; p < 3; p++) begin
         write_threshold(THR_W'($urandom_range(0, 4095)));
         steady_flow = (p == 1);
         repeat (6) send_random_window(13);
      end
      steady_flow = 1'b0;
   endtask

   // Random thresholds over the full range, ending on a partial window
   task automatic test_random_mix();
      for (int p = 0; p < 2; p++) begin
         write_threshold(THR_W'($urandom_range(0, 65535)));
         repeat (9) send_random_window(16);
      end
      repeat ($urandom_range(1, WINDOW_LEN - 1)) begin
         send_sample(SAMPLE_W'($urandom_range(0, 65535)));
      end
   endtask

   // Result side back-pressure
   always @(negedge clock) begin
      int gap;
      if (ready_left > 0) begin
         ready_left = ready_left - 1;
      end else if (steady_flow || !rsp_tready) begin
         rsp_tready <= 1'b1;
         ready_left = $urandom_range(0, 7);
      end else begin
         gap = pick_gap();
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            ready_left = gap - 1;
         end else begin
            ready_left = $urandom_range(0, 7);
         end
      end
   end

   // Compare each result beat with the oldest pending window
   always @(posedge clock) begin
      deviation_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_windows.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= 10) begin
               $display("unexpected result beat: q4=%0d flag=%0b",
                        rsp_tdata[Q4_W-1:0], rsp_tdata[Q4_W]);
            end
         end else begin
            want = pending_windows.pop_front();
            if (rsp_tdata[Q4_W-1:0] !== want.intensity_q4 ||
                rsp_tdata[Q4_W] !== want.vibration_on) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10) begin
                  $display("window mismatch: expected q4=%0d flag=%0b, got q4=%0d flag=%0b",
                           want.intensity_q4, want.vibration_on,
                           rsp_tdata[Q4_W-1:0], rsp_tdata[Q4_W]);
               end
            end
         end
      end
   end

   // Run time guard
   initial begin
      #20_000_000;
      $display("vibration_stddev_detector_unit verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_threshold_boundary();
      test_zero_threshold();
      test_full_threshold();
      test_matched_scale();
      test_random_mix();
      wait_for_idle();
      if (fault_count == 0) begin
         $display("vibration_stddev_detector_unit verification clean");
      end else begin
         $display("vibration_stddev_detector_unit verification failed");
      end
      $finish;
   end

endmodule
